// ----- rtl/pool_allocator_oldest_eviction_core_assert.svh -----
// Assertion macros used by the pool allocator core.
`ifndef POOL_ALLOCATOR_OLDEST_EVICTION_CORE_ASSERT_SVH
`define POOL_ALLOCATOR_OLDEST_EVICTION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define PAOE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pool allocator assertion failed");
// Next-cycle implication.
`define PAOE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pool allocator assertion failed");
`else
`define PAOE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PAOE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/paoe_pkg.sv -----
// Shared constants and codes of the pool allocator.
`default_nettype none
package paoe_pkg;
   localparam int SLOTS_DEFAULT = 64;
   localparam int SLOT_FIELD_W  = 6;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic STATUS_OK         = 1'b0;
   localparam logic STATUS_NOT_ACTIVE = 1'b1;
endpackage
`default_nettype wire

// ----- rtl/paoe_if.sv -----
// Request and response channel interfaces of the pool allocator.
`default_nettype none
interface paoe_req_if import paoe_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    func;
   logic [SLOT_FIELD_W-1:0] slot_to_free;

   modport source (output valid, output func, output slot_to_free, input ready);
   modport sink   (input valid, input func, input slot_to_free, output ready);
endinterface

interface paoe_rsp_if import paoe_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [SLOT_FIELD_W-1:0] granted_slot;
   logic                    evicted;
   logic                    status;

   modport source (output valid, output granted_slot, output evicted, output status,
                   input ready);
   modport sink   (input valid, input granted_slot, input evicted, input status,
                   output ready);
endinterface
`default_nettype wire

// ----- rtl/pool_allocator_oldest_eviction_core.sv -----
// Pool allocator with LIFO free store and oldest-first eviction.
//
// Channels: req_chan carries one request (func, slot_to_free); rsp_chan returns
// exactly one response (granted_slot, evicted, status) per request, in order.
// Both use valid/ready; a transfer happens on a rising edge with both high.
// Sequence: an accepted request reads the free store and the link and
// active-bit memories (registered reads); in the update state that follows,
// once the output register is free, all list updates are written and the
// response register loads. req_chan.ready is low during the update state, so
// the block takes no new request until the last one's update is done.
// Reset (synchronous, active high) starts a clearing pass over the active-bit
// memory, one entry per cycle; req_chan.ready stays low until it ends. The
// free store needs no pass: a high-water mark tells written entries from those
// never written, which are taken as their own index.
// Stall: a response waits in the output register while rsp_chan.ready is low;
// one more request is still accepted and parks in its update cycle until the
// output register is free, then req_chan.ready stays low.
`default_nettype none
`include "pool_allocator_oldest_eviction_core_assert.svh"
module pool_allocator_oldest_eviction_core import paoe_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   paoe_req_if.sink   req_chan,
   paoe_rsp_if.source rsp_chan
);
   localparam int SW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [SW-1:0] clr_ff, clr_in;
   logic [CW-1:0] free_count_ff, free_count_in;
   logic [CW-1:0] hw_ff, hw_in;
   logic [SW-1:0] newest_ff, newest_in;
   logic [SW-1:0] oldest_ff, oldest_in;

   // latched request
   logic                    func_ff;
   logic [SLOT_FIELD_W-1:0] tgt_ff;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SLOT_FIELD_W-1:0] granted_ff, granted_in;
   logic                    evicted_ff, evicted_in;
   logic                    status_ff, status_in;

   // memories and their registered read data
   logic [SW-1:0] free_mem   [SLOTS];
   logic [SW-1:0] newer_mem  [SLOTS];
   logic [SW-1:0] older_mem  [SLOTS];
   logic          active_mem [SLOTS];
   logic [SW-1:0] free_rd_ff, newer_rd_ff, older_rd_ff;
   logic          active_rd_ff;

   // write ports
   logic          free_we, newer_we, older_we, active_we;
   logic [SW-1:0] free_wa, newer_wa, older_wa, active_wa;
   logic [SW-1:0] free_wd, newer_wd, older_wd;
   logic          active_wd;

   logic          accept, exec_go, list_empty, pool_empty, tgt_ok, free_ok;
   logic          nw_valid, od_valid;
   logic [CW-1:0] ptr_full, ptr_dec;
   logic [SW-1:0] ptr, tgt_idx, tgt_idx_req, newer_ra, pop_s, alloc_s;

   // handshake
   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign accept                = req_chan.valid && req_chan.ready;
   assign exec_go               = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.granted_slot = granted_ff;
   assign rsp_chan.evicted      = evicted_ff;
   assign rsp_chan.status       = status_ff;

   // free store pointer and list occupancy
   assign ptr_full    = SLOTS_C - free_count_ff;
   assign ptr_dec     = ptr_full - CW'(1);
   assign ptr         = ptr_full[SW-1:0];
   assign list_empty  = (free_count_ff == SLOTS_C);
   assign pool_empty  = (free_count_ff == '0);
   assign tgt_idx_req = SW'(req_chan.slot_to_free);
   assign tgt_idx     = SW'(tgt_ff);
   assign newer_ra    = (req_chan.func == FUNC_ALLOC) ? oldest_ff : tgt_idx_req;

   // slot from the free store: entries never written are taken as their own index
   assign pop_s    = (ptr_full >= hw_ff) ? ptr : free_rd_ff;
   assign alloc_s  = pool_empty ? oldest_ff : pop_s;
   assign tgt_ok   = int'(tgt_ff) < SLOTS;
   assign free_ok  = tgt_ok && active_rd_ff && !list_empty;
   assign nw_valid = (tgt_idx != newest_ff);
   assign od_valid = (tgt_idx != oldest_ff);

   // sequencer and list update
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      free_count_in = free_count_ff;
      hw_in         = hw_ff;
      newest_in     = newest_ff;
      oldest_in     = oldest_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      granted_in    = granted_ff;
      evicted_in    = evicted_ff;
      status_in     = status_ff;
      free_we       = 1'b0;
      free_wa       = ptr_dec[SW-1:0];
      free_wd       = tgt_idx;
      newer_we      = 1'b0;
      newer_wa      = newest_ff;
      newer_wd      = alloc_s;
      older_we      = 1'b0;
      older_wa      = alloc_s;
      older_wd      = newest_ff;
      active_we     = 1'b0;
      active_wa     = alloc_s;
      active_wd     = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            // sweep the active bits to zero
            active_we = 1'b1;
            active_wa = clr_ff;
            active_wd = 1'b0;
            clr_in    = clr_ff + SW'(1);
            if (int'(clr_ff) == SLOTS - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (func_ff == FUNC_ALLOC) begin
                  granted_in = SLOT_FIELD_W'(alloc_s);
                  evicted_in = pool_empty;
                  status_in  = STATUS_OK;
                  if (pool_empty) begin
                     // unlink the oldest slot; the next newer one becomes oldest
                     oldest_in = newer_rd_ff;
                  end else begin
                     free_count_in = free_count_ff - CW'(1);
                     if (ptr_full >= hw_ff) begin
                        hw_in = ptr_full + CW'(1);
                     end
                  end
                  // link the slot at the newest end
                  if (list_empty) begin
                     oldest_in = alloc_s;
                  end else begin
                     older_we = 1'b1;
                     newer_we = 1'b1;
                  end
                  newest_in = alloc_s;
                  active_we = 1'b1;
               end else begin
                  granted_in = '0;
                  evicted_in = 1'b0;
                  if (free_ok) begin
                     status_in = STATUS_OK;
                     // bridge the neighbors around the freed slot
                     if (nw_valid) begin
                        older_we = 1'b1;
                        older_wa = newer_rd_ff;
                        older_wd = older_rd_ff;
                     end else begin
                        newest_in = older_rd_ff;
                     end
                     if (od_valid) begin
                        newer_we = 1'b1;
                        newer_wa = older_rd_ff;
                        newer_wd = newer_rd_ff;
                     end else begin
                        oldest_in = newer_rd_ff;
                     end
                     active_we     = 1'b1;
                     active_wa     = tgt_idx;
                     active_wd     = 1'b0;
                     free_we       = 1'b1;
                     free_count_in = free_count_ff + CW'(1);
                  end else begin
                     status_in = STATUS_NOT_ACTIVE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         free_count_ff <= SLOTS_C;
         hw_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         free_count_ff <= free_count_in;
         hw_ff         <= hw_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // list ends, latched request and response payload
   always_ff @(posedge clock) begin
      newest_ff  <= newest_in;
      oldest_ff  <= oldest_in;
      granted_ff <= granted_in;
      evicted_ff <= evicted_in;
      status_ff  <= status_in;
      if (accept) begin
         func_ff <= req_chan.func;
         tgt_ff  <= req_chan.slot_to_free;
      end
   end

   // free store memory
   always_ff @(posedge clock) begin
      if (free_we) begin
         free_mem[free_wa] <= free_wd;
      end
      if (accept) begin
         free_rd_ff <= free_mem[ptr];
      end
   end

   // newer-link memory
   always_ff @(posedge clock) begin
      if (newer_we) begin
         newer_mem[newer_wa] <= newer_wd;
      end
      if (accept) begin
         newer_rd_ff <= newer_mem[newer_ra];
      end
   end

   // older-link memory
   always_ff @(posedge clock) begin
      if (older_we) begin
         older_mem[older_wa] <= older_wd;
      end
      if (accept) begin
         older_rd_ff <= older_mem[tgt_idx_req];
      end
   end

   // active-bit memory
   always_ff @(posedge clock) begin
      if (active_we) begin
         active_mem[active_wa] <= active_wd;
      end
      if (accept) begin
         active_rd_ff <= active_mem[tgt_idx_req];
      end
   end

   // checks
   `PAOE_ASSERT_NEXT(a_accept_exec, clock, reset, accept, state_ff == ST_EXEC)
   `PAOE_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, free_count_ff <= SLOTS_C)
   `PAOE_ASSERT_IMPL(a_high_water, clock, reset, 1'b1, ptr_full <= hw_ff)
   `PAOE_ASSERT_NEXT(a_evict_empty, clock, reset, exec_go && (func_ff == FUNC_ALLOC), evicted_ff == ($past(free_count_ff) == '0))
   `PAOE_ASSERT_IMPL(a_status_alloc, clock, reset, rsp_valid_ff && (status_ff == STATUS_NOT_ACTIVE), !evicted_ff && (granted_ff == '0))
endmodule
`default_nettype wire
